>>> rtl/core/assert_macros.svh
// Assertion macros shared by the remap address RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of aclk, ignored while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Condition that must never hold at a rising edge of aclk outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

>>> rtl/core/tlra_pkg.sv
// Package with the types and constants of the tensor layout remap address block.
`timescale 1ns / 1ps
`default_nettype none

package tlra_pkg;

    // Remap modes; the fourth code is unused and gives index zero, outside set.
    typedef enum logic [1:0] {
        MODE_ZERO_PAD   = 2'd0,
        MODE_GRID_PAD   = 2'd1,
        MODE_CHAN_SPLIT = 2'd2
    } remap_mode_t;

    // Register indexes on the configuration port.
    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 13;

    localparam logic [CfgIndexWidth-1:0] REG_REMAP_MODE   = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_SRC_CHANNELS = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_SRC_ROWS     = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_SRC_COLS     = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_PAD_WIDTH    = 3'd4;
    localparam logic [CfgIndexWidth-1:0] REG_DST_ROWS     = 3'd5;
    localparam logic [CfgIndexWidth-1:0] REG_DST_COLS     = 3'd6;
    localparam logic [CfgIndexWidth-1:0] REG_DST_CHANNELS = 3'd7;

    // Field widths.
    localparam int BatchWidth = 8;
    localparam int ChanWidth  = 12;
    localparam int RowWidth   = 10;
    localparam int ColWidth   = 10;
    localparam int ValueWidth = 32;
    localparam int DestWidth  = 42;

    localparam int InDataWidth  = 72;
    localparam int OutDataWidth = 80;

endpackage : tlra_pkg

`default_nettype wire

>>> rtl/core/tensor_layout_remap_address.sv
// Top level of the tensor layout remap address generator: a five-stage pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted input beat passes through the five register stages to its result beat on m_.
// Throughput: one beat per cycle while m_tready is high; the stages each hold one beat and move
// on independently, so an empty stage is filled even while a finished result waits to be taken.
// Reset: aresetn is synchronous and active low; it empties every stage and returns the
// configuration registers to mode zero pad, pad width 0 and all sizes 1. cfg_ready is always high.
module tensor_layout_remap_address (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Configuration write channel.
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tlra_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  wire logic [tlra_pkg::CfgDataWidth-1:0]   cfg_data,
    // Input stream.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // s_tdata, from bit 0: batch_index[7:0], channel_index[19:8], row_index[29:20],
    // col_index[39:30], element_value[71:40].
    input  wire logic [tlra_pkg::InDataWidth-1:0]    s_tdata,
    // Result stream.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // m_tdata, from bit 0: dest_index[41:0], out_value[73:42], zeros[79:74].
    output logic [tlra_pkg::OutDataWidth-1:0]        m_tdata,
    // m_tuser, from bit 0: outside[0].
    output logic                                     m_tuser
);

    import tlra_pkg::*;

`include "assert_macros.svh"

    // ------------------------------------------------------------------
    // Configuration registers. Users change them only while the pipeline is idle; not enforced.
    // ------------------------------------------------------------------
    logic [1:0]  remap_mode_reg;
    logic [12:0] src_channels_reg;
    logic [10:0] src_rows_reg;
    logic [10:0] src_cols_reg;
    logic [3:0]  pad_width_reg;
    logic [10:0] dst_rows_reg;
    logic [10:0] dst_cols_reg;
    logic [12:0] dst_channels_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remap_mode_reg   <= MODE_ZERO_PAD;
            src_channels_reg <= 13'd1;
            src_rows_reg     <= 11'd1;
            src_cols_reg     <= 11'd1;
            pad_width_reg    <= 4'd0;
            dst_rows_reg     <= 11'd1;
            dst_cols_reg     <= 11'd1;
            dst_channels_reg <= 13'd1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_REMAP_MODE:   remap_mode_reg   <= cfg_data[1:0];
                REG_SRC_CHANNELS: src_channels_reg <= cfg_data[12:0];
                REG_SRC_ROWS:     src_rows_reg     <= cfg_data[10:0];
                REG_SRC_COLS:     src_cols_reg     <= cfg_data[10:0];
                REG_PAD_WIDTH:    pad_width_reg    <= cfg_data[3:0];
                REG_DST_ROWS:     dst_rows_reg     <= cfg_data[10:0];
                REG_DST_COLS:     dst_cols_reg     <= cfg_data[10:0];
                REG_DST_CHANNELS: dst_channels_reg <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. Each stage loads when it is empty or when the stage after
    // it loads, so bubbles close up and a stall at the output loses nothing.
    // ------------------------------------------------------------------
    logic st1_valid_reg, st2_valid_reg, st3_valid_reg, st4_valid_reg, st5_valid_reg;
    logic en1, en2, en3, en4, en5;

    assign en5 = !st5_valid_reg || m_tready;
    assign en4 = !st4_valid_reg || en5;
    assign en3 = !st3_valid_reg || en4;
    assign en2 = !st2_valid_reg || en3;
    assign en1 = !st1_valid_reg || en2;

    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
            st5_valid_reg <= 1'b0;
        end else begin
            if (en1) begin
                st1_valid_reg <= s_tvalid;
            end
            if (en2) begin
                st2_valid_reg <= st1_valid_reg;
            end
            if (en3) begin
                st3_valid_reg <= st2_valid_reg;
            end
            if (en4) begin
                st4_valid_reg <= st3_valid_reg;
            end
            if (en5) begin
                st5_valid_reg <= st4_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: unpack the beat and choose the plane sizes and offsets of the
    // active mode. Zero pad grows the plane by twice the pad width and shifts
    // the element by the pad; grid pad and channel split use the destination
    // grid. The coordinate bound checks of zero pad and grid pad are done here.
    // ------------------------------------------------------------------
    logic [BatchWidth-1:0] in_batch;
    logic [ChanWidth-1:0]  in_chan;
    logic [RowWidth-1:0]   in_row;
    logic [ColWidth-1:0]   in_col;
    logic [ValueWidth-1:0] in_value;

    assign in_batch = s_tdata[7:0];
    assign in_chan  = s_tdata[19:8];
    assign in_row   = s_tdata[29:20];
    assign in_col   = s_tdata[39:30];
    assign in_value = s_tdata[71:40];

    logic [11:0] dim_a_next, dim_b_next;
    logic [12:0] chan_mult_next;
    logic [10:0] row_off_next, col_off_next;
    logic        outside1_next;
    logic [11:0] padded_rows, padded_cols;
    logic [4:0]  pad_twice;

    assign pad_twice   = {pad_width_reg, 1'b0};
    assign padded_rows = {1'b0, src_rows_reg} + {7'd0, pad_twice};
    assign padded_cols = {1'b0, src_cols_reg} + {7'd0, pad_twice};

    always_comb begin
        dim_a_next     = {1'b0, dst_rows_reg};
        dim_b_next     = {1'b0, dst_cols_reg};
        chan_mult_next = src_channels_reg;
        row_off_next   = {1'b0, in_row};
        col_off_next   = {1'b0, in_col};
        outside1_next  = 1'b1;
        unique case (remap_mode_reg)
            MODE_ZERO_PAD: begin
                dim_a_next    = padded_rows;
                dim_b_next    = padded_cols;
                row_off_next  = {1'b0, in_row} + {7'd0, pad_width_reg};
                col_off_next  = {1'b0, in_col} + {7'd0, pad_width_reg};
                outside1_next = ({1'b0, in_chan} >= src_channels_reg)
                             || ({1'b0, in_row} >= src_rows_reg)
                             || ({1'b0, in_col} >= src_cols_reg);
            end
            MODE_GRID_PAD: begin
                outside1_next = ({1'b0, in_chan} >= src_channels_reg)
                             || ({1'b0, in_row} >= dst_rows_reg)
                             || ({1'b0, in_col} >= dst_cols_reg);
            end
            MODE_CHAN_SPLIT: begin
                // The bound is the whole volume, checked once it is known.
                chan_mult_next = dst_channels_reg;
                outside1_next  = 1'b0;
            end
            default: begin
                outside1_next = 1'b1;
            end
        endcase
    end

    logic [11:0]           dim_a1_reg, dim_b1_reg;
    logic [12:0]           chan_mult1_reg;
    logic [10:0]           row_off1_reg, col_off1_reg;
    logic                  outside1_reg;
    logic [1:0]            mode1_reg;
    logic [BatchWidth-1:0] batch1_reg;
    logic [ChanWidth-1:0]  chan1_reg;
    logic [ValueWidth-1:0] value1_reg;

    always_ff @(posedge aclk) begin
        if (en1) begin
            dim_a1_reg     <= dim_a_next;
            dim_b1_reg     <= dim_b_next;
            chan_mult1_reg <= chan_mult_next;
            row_off1_reg   <= row_off_next;
            col_off1_reg   <= col_off_next;
            outside1_reg   <= outside1_next;
            mode1_reg      <= remap_mode_reg;
            batch1_reg     <= in_batch;
            chan1_reg      <= in_chan;
            value1_reg     <= in_value;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: plane size and the row term of the in-plane offset.
    // ------------------------------------------------------------------
    logic [23:0] plane_next;
    logic [22:0] row_term_next;

    assign plane_next    = {12'd0, dim_a1_reg} * {12'd0, dim_b1_reg};
    assign row_term_next = {11'd0, dim_b1_reg} * {12'd0, row_off1_reg};

    logic [23:0]           plane2_reg;
    logic [22:0]           row_term2_reg;
    logic [12:0]           chan_mult2_reg;
    logic [10:0]           col_off2_reg;
    logic                  outside2_reg;
    logic [1:0]            mode2_reg;
    logic [BatchWidth-1:0] batch2_reg;
    logic [ChanWidth-1:0]  chan2_reg;
    logic [ValueWidth-1:0] value2_reg;

    always_ff @(posedge aclk) begin
        if (en2) begin
            plane2_reg     <= plane_next;
            row_term2_reg  <= row_term_next;
            chan_mult2_reg <= chan_mult1_reg;
            col_off2_reg   <= col_off1_reg;
            outside2_reg   <= outside1_reg;
            mode2_reg      <= mode1_reg;
            batch2_reg     <= batch1_reg;
            chan2_reg      <= chan1_reg;
            value2_reg     <= value1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: size of one batch (channels times plane, which in channel
    // split mode is the whole volume) and the channel term.
    // ------------------------------------------------------------------
    logic [36:0] batch_size_next;
    logic [35:0] chan_term_next;

    assign batch_size_next = {24'd0, chan_mult2_reg} * {13'd0, plane2_reg};
    assign chan_term_next  = {12'd0, plane2_reg} * {24'd0, chan2_reg};

    logic [36:0]           batch_size3_reg;
    logic [35:0]           chan_term3_reg;
    logic [22:0]           row_term3_reg;
    logic [10:0]           col_off3_reg;
    logic                  outside3_reg;
    logic [1:0]            mode3_reg;
    logic [BatchWidth-1:0] batch3_reg;
    logic [ChanWidth-1:0]  chan3_reg;
    logic [ValueWidth-1:0] value3_reg;

    always_ff @(posedge aclk) begin
        if (en3) begin
            batch_size3_reg <= batch_size_next;
            chan_term3_reg  <= chan_term_next;
            row_term3_reg   <= row_term2_reg;
            col_off3_reg    <= col_off2_reg;
            outside3_reg    <= outside2_reg;
            mode3_reg       <= mode2_reg;
            batch3_reg      <= batch2_reg;
            chan3_reg       <= chan2_reg;
            value3_reg      <= value2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: batch offset, the sum of the in-batch terms (in channel split
    // mode the channel index alone), and the volume bound of channel split mode.
    // ------------------------------------------------------------------
    logic [44:0] batch_off_full;
    logic [41:0] batch_off_next;
    logic [41:0] inner_next;
    logic        outside4_next;

    assign batch_off_full = {8'd0, batch_size3_reg} * {37'd0, batch3_reg};
    assign batch_off_next = batch_off_full[41:0];

    always_comb begin
        if (mode3_reg == MODE_CHAN_SPLIT) begin
            inner_next    = {30'd0, chan3_reg};
            outside4_next = {25'd0, chan3_reg} >= batch_size3_reg;
        end else begin
            inner_next    = {6'd0, chan_term3_reg} + {19'd0, row_term3_reg}
                          + {31'd0, col_off3_reg};
            outside4_next = outside3_reg;
        end
    end

    logic [41:0]           batch_off4_reg;
    logic [41:0]           inner4_reg;
    logic                  outside4_reg;
    logic [1:0]            mode4_reg;
    logic [ValueWidth-1:0] value4_reg;

    always_ff @(posedge aclk) begin
        if (en4) begin
            batch_off4_reg <= batch_off_next;
            inner4_reg     <= inner_next;
            outside4_reg   <= outside4_next;
            mode4_reg      <= mode3_reg;
            value4_reg     <= value3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: final index, wrapping at 42 bits. The unused mode code gives
    // index zero. This stage is the output register.
    // ------------------------------------------------------------------
    logic                  mode4_unused;
    logic [DestWidth-1:0]  dest_next;

    assign mode4_unused = (mode4_reg != MODE_ZERO_PAD) && (mode4_reg != MODE_GRID_PAD)
                       && (mode4_reg != MODE_CHAN_SPLIT);
    assign dest_next    = mode4_unused ? '0 : (batch_off4_reg + inner4_reg);

    logic [DestWidth-1:0]  dest5_reg;
    logic [ValueWidth-1:0] value5_reg;
    logic                  outside5_reg;

    always_ff @(posedge aclk) begin
        if (en5) begin
            dest5_reg    <= dest_next;
            value5_reg   <= value4_reg;
            outside5_reg <= outside4_reg;
        end
    end

    assign m_tvalid = st5_valid_reg;
    assign m_tdata  = {6'd0, value5_reg, dest5_reg};
    assign m_tuser  = outside5_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `ASSERT_CLK(a_empty_front_ready, !st1_valid_reg |-> s_tready,
        "input refused although the first stage is empty")
    `ASSERT_NEVER(a_full_stall_accept,
        st1_valid_reg && st2_valid_reg && st3_valid_reg && st4_valid_reg
            && st5_valid_reg && !m_tready && s_tready,
        "input taken while every stage is full and the output stalls")
    `ASSERT_CLK(a_stage4_moves_out, st4_valid_reg && en5 |=> st5_valid_reg,
        "a beat was lost between the last two stages")
    `ASSERT_CLK(a_unused_mode_result, st4_valid_reg && en5 && mode4_unused
        |=> m_tuser && (m_tdata[41:0] == 42'd0),
        "unused mode must give index zero with outside set")

endmodule : tensor_layout_remap_address

`default_nettype wire
